/* rtl/static_linked_list_engine_macros.svh */
// assertion helpers shared by the engine
`ifndef STATIC_LINKED_LIST_ENGINE_MACROS_SVH
`define STATIC_LINKED_LIST_ENGINE_MACROS_SVH

// same-cycle implication
`define SLLE_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLLE_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/slle_pkg.sv */
package slle_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 6;
  localparam int ELEM_W = 8;
  localparam int LEN_W  = 6;

  localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [POS_W-1:0]  pidx;
    logic [POS_W-1:0]  lidx;
    logic [ELEM_W-1:0] elem;
  } slle_cmd_t;

endpackage

/* rtl/slle_cell.sv */
module slle_cell import slle_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  slle_cmd_t         cmd,
  input  logic [ELEM_W-1:0] left,
  input  logic [ELEM_W-1:0] right,
  input  logic [ELEM_W-1:0] head,
  output logic [ELEM_W-1:0] value
);

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic [ELEM_W-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      OP_INS: begin
        // cells at and after the slot move one place toward the tail
        if (IDX > cmd.pidx) begin
          value_next = left;
        end else if (IDX == cmd.pidx) begin
          value_next = cmd.elem;
        end
      end
      OP_DEL: begin
        if (IDX >= cmd.pidx) begin
          value_next = right;
        end
      end
      OP_ROT: begin
        // rotate the occupied cells, front element wraps to the tail
        if (IDX == cmd.lidx) begin
          value_next = head;
        end else if (IDX < cmd.lidx) begin
          value_next = right;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* rtl/static_linked_list_engine.sv */
// Ordered list of byte elements with insert, delete and traverse commands.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; kind selects insert before position, delete at position, or
// traverse. position is 1-based, element is the byte stored by an insert.
// Result channel: strobe marks each result for exactly one cycle, with
// status, value, last and length (list length after the operation).
// Insert, delete, errors and unused kinds give one result in the cycle after
// the transaction and leave busy low, so a new command may follow at once.
// Traverse holds busy high while it runs and emits one element per cycle:
// the transaction moves the block into the traverse state, and each element
// is then registered from the front cell as the cell row rotates, last on the
// final one; an empty list gives a single error result in the cycle after
// the transaction. A traverse emits length elements (up to SLOTS-2).
// The list lives in a row of SLOTS-2 cells; on insert and delete the cells
// from the position to the tail shift together.
// Reset (rst, synchronous) empties the list and clears busy and strobe.
// The receiver cannot stall; results are never held back.
`include "static_linked_list_engine_macros.svh"

module static_linked_list_engine import slle_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [KIND_W-1:0] kind,
  input  logic [POS_W-1:0]  position,
  input  logic [ELEM_W-1:0] element,
  output logic              strobe,
  output logic              status,
  output logic [ELEM_W-1:0] value,
  output logic              last,
  output logic [LEN_W-1:0]  length
);

  localparam int CAP = SLOTS - 2;
  localparam int CW  = $clog2(SLOTS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TRAV = 1'b1;

  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] trav_n;

  logic              accept;
  logic              ins_ok;
  logic              del_ok;
  logic              trav_last;
  logic [POS_W:0]    cnt_ext;
  logic [CW-1:0]     count_inc;
  slle_cmd_t         cmd;
  logic [ELEM_W-1:0] vals [CAP];

  assign accept    = start && !busy;
  assign busy      = (state == ST_TRAV);
  assign length    = LEN_W'(count);
  assign cnt_ext   = (POS_W+1)'(count);
  assign count_inc = count + 1'b1;
  assign ins_ok    = (position != '0) && ({1'b0, position} <= cnt_ext + 1'b1)
                     && (count < CW'(CAP));
  assign del_ok    = (position != '0) && ({1'b0, position} <= cnt_ext);
  assign trav_last = (trav_n == count - 1'b1);

  always_comb begin
    cmd.op   = OP_HOLD;
    cmd.pidx = position - 1'b1;
    cmd.lidx = POS_W'(count) - 1'b1;
    cmd.elem = element;
    priority if (state == ST_TRAV) begin
      cmd.op = OP_ROT;
    end else if (accept && kind == KIND_INSERT && ins_ok) begin
      cmd.op = OP_INS;
    end else if (accept && kind == KIND_DELETE && del_ok) begin
      cmd.op = OP_DEL;
    end
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    slle_cell #(.INDEX(i)) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .left ((i == 0) ? element : vals[(i == 0) ? 0 : i-1]),
      .right((i == CAP-1) ? vals[0] : vals[(i == CAP-1) ? 0 : i+1]),
      .head (vals[0]),
      .value(vals[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      trav_n <= '0;
      strobe <= 1'b0;
      status <= 1'b0;
      value  <= '0;
      last   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (state == ST_TRAV) begin
        strobe <= 1'b1;
        status <= 1'b0;
        value  <= vals[0];
        last   <= trav_last;
        trav_n <= trav_n + 1'b1;
        if (trav_last) begin
          state <= ST_IDLE;
        end
      end else if (accept) begin
        strobe <= 1'b1;
        status <= 1'b1;
        value  <= '0;
        last   <= 1'b1;
        unique case (kind)
          KIND_INSERT: begin
            if (ins_ok) begin
              status <= 1'b0;
              count  <= count_inc;
            end
          end
          KIND_DELETE: begin
            if (del_ok) begin
              status <= 1'b0;
              count  <= count - 1'b1;
            end
          end
          KIND_TRAVERSE: begin
            // non-empty list: elements come out of the front cell
            if (count != '0) begin
              strobe <= 1'b0;
              state  <= ST_TRAV;
              trav_n <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  `SLLE_ASSERT_NOW(a_len_cap, clk, rst, strobe, length <= LEN_W'(CAP), "length above capacity")
  `SLLE_ASSERT_NEXT(a_trav_emit, clk, rst, state == ST_TRAV, strobe && !status, "traverse gap")
  `SLLE_ASSERT_NEXT(a_single, clk, rst, accept && kind != KIND_TRAVERSE, strobe && last, "no result")
  `SLLE_ASSERT_NEXT(a_ins_cnt, clk, rst, cmd.op == OP_INS, count == $past(count_inc), "insert count")

endmodule
